FILE: src/upwind_advection_stepper_top_defines.svh
// ----------------------------------------------------------------------------
// upwind advection stepper assertion macros
// shared property forms for the top level checks, clocked on clk and held off
// while arst_n is low
// ----------------------------------------------------------------------------
`ifndef UPWIND_ADVECTION_STEPPER_TOP_DEFINES_SVH
`define UPWIND_ADVECTION_STEPPER_TOP_DEFINES_SVH

// same-cycle implication
`define UAS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("upwind stepper check failed");

// next-cycle implication
`define UAS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("upwind stepper check failed");

`endif

FILE: src/uas_pkg.sv
// ----------------------------------------------------------------------------
// uas_pkg
// shared types and constants of the upwind advection stepper
// ----------------------------------------------------------------------------
`default_nettype none

package uas_pkg;

	localparam int GRID_CELLS_DEF = 512;
	localparam int VALUE_BITS_DEF = 24;

	localparam int ACTION_W    = 2;
	localparam int INDEX_W     = 9;
	localparam int VALUE_W     = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int COURANT_W   = 17;
	localparam int CELLS_W     = 10;

	localparam logic [COURANT_W-1:0] ONE_Q16       = 17'd65536;
	localparam logic [COURANT_W-1:0] COURANT_RESET = 17'd32768;
	localparam logic                 RK2_RESET     = 1'b0;
	localparam logic [CELLS_W-1:0]   CELLS_RESET   = 10'd500;
	localparam logic [CELLS_W-1:0]   MIN_CELLS     = 10'd2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE   = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_READ    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COURANT = 2'd0,
		CFG_RK2     = 2'd1,
		CFG_CELLS   = 2'd2
	} cfg_reg_t;

	// which sweep the datapath is running
	typedef enum logic [1:0] {
		PASS_EULER,
		PASS_SLOPE,
		PASS_FINAL
	} pass_t;

	typedef enum logic [1:0] {
		RPL_ZERO,
		RPL_ERROR,
		RPL_READ,
		RPL_SAT
	} reply_t;

	typedef struct packed {
		action_t                    action;
		logic [INDEX_W-1:0]         cell_index;
		logic signed [VALUE_W-1:0]  cell_value;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  read_value;
		logic                       index_error;
		logic                       saturated;
	} result_t;

	typedef struct packed {
		logic [COURANT_W-1:0]  courant;
		logic                  rk2;
		logic [CELLS_W-1:0]    cells;
	} cfg_t;

	typedef struct packed {
		logic    rd_en;
		logic    sweep;
		logic    wrap;
		logic    host_wr;
		logic    clr_sat;
		logic    reply_en;
		reply_t  reply;
		pass_t   pass;
	} dp_cmd_t;

endpackage

`default_nettype wire

FILE: src/uas_cfg.sv
// ----------------------------------------------------------------------------
// uas_cfg
// configuration registers with the courant and cell count limits applied
// ----------------------------------------------------------------------------
`default_nettype none

module uas_cfg #(
	parameter int GRID_CELLS = uas_pkg::GRID_CELLS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [uas_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [uas_pkg::CFG_DATA_W-1:0]   cfg_data,
	output uas_pkg::cfg_t                         cfg
);
	import uas_pkg::*;

	logic [COURANT_W-1:0] courant_q;
	logic                 rk2_q;
	logic [CELLS_W-1:0]   cells_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q <= COURANT_RESET;
			rk2_q     <= RK2_RESET;
			cells_q   <= CELLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COURANT: courant_q <= cfg_data[COURANT_W-1:0];
				CFG_RK2:     rk2_q     <= cfg_data[0];
				CFG_CELLS:   cells_q   <= cfg_data[CELLS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.courant = (courant_q > ONE_Q16) ? ONE_Q16 : courant_q;
		cfg.rk2     = rk2_q;
		if (cells_q < MIN_CELLS) begin
			cfg.cells = MIN_CELLS;
		end else if (int'(cells_q) > GRID_CELLS) begin
			cfg.cells = CELLS_W'(GRID_CELLS);
		end else begin
			cfg.cells = cells_q;
		end
	end

endmodule

`default_nettype wire

FILE: src/uas_ctrl.sv
// ----------------------------------------------------------------------------
// uas_ctrl
// sequencer: decodes items, walks the grid addresses for each sweep and
// issues replies to the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module uas_ctrl #(
	parameter int GRID_CELLS = uas_pkg::GRID_CELLS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  uas_pkg::item_t                      item,
	input  uas_pkg::cfg_t                       cfg,
	output logic                                busy,
	output uas_pkg::dp_cmd_t                    cmd,
	output logic [$clog2(GRID_CELLS)-1:0]       addr
);
	import uas_pkg::*;

	localparam int ADDR_W = $clog2(GRID_CELLS);
	localparam int EXT_W  = (ADDR_W > CELLS_W) ? ADDR_W : CELLS_W;
	// last drain count: the final datapath write of a sweep lands as the drain ends
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	logic                busy_q;
	dp_cmd_t             cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CELLS_W-1:0]  cnt_q;
	logic [1:0]          dcnt_q;

	logic [CELLS_W-1:0]  last_cell;
	logic                idx_bad;
	logic [EXT_W-1:0]    idx_x;
	logic [EXT_W-1:0]    cnt_x;
	logic [EXT_W-1:0]    last_x;
	logic [ADDR_W-1:0]   idx_addr;
	logic [ADDR_W-1:0]   cnt_addr;
	logic [ADDR_W-1:0]   last_addr;

	always_comb begin
		last_cell = cfg.cells - 1'b1;
		idx_bad   = CELLS_W'(item.cell_index) >= cfg.cells;
		idx_x     = EXT_W'(item.cell_index);
		cnt_x     = EXT_W'(cnt_q);
		last_x    = EXT_W'(last_cell);
		idx_addr  = idx_x[ADDR_W-1:0];
		cnt_addr  = cnt_x[ADDR_W-1:0];
		last_addr = last_x[ADDR_W-1:0];
	end

	assign busy = busy_q;
	assign cmd  = cmd_q;
	assign addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			cmd_q   <= '0;
			addr_q  <= '0;
			cnt_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			cmd_q.rd_en    <= 1'b0;
			cmd_q.sweep    <= 1'b0;
			cmd_q.wrap     <= 1'b0;
			cmd_q.host_wr  <= 1'b0;
			cmd_q.clr_sat  <= 1'b0;
			cmd_q.reply_en <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (item.action) inside
							ACT_ADVANCE: begin
								// first read fetches the wrap cell
								cmd_q.rd_en   <= 1'b1;
								cmd_q.sweep   <= 1'b1;
								cmd_q.wrap    <= 1'b1;
								cmd_q.clr_sat <= 1'b1;
								cmd_q.pass    <= cfg.rk2 ? PASS_SLOPE : PASS_EULER;
								addr_q        <= last_addr;
								cnt_q         <= '0;
								busy_q        <= 1'b1;
								state_q       <= ST_SWEEP;
							end
							ACT_WRITE, ACT_READ: begin
								if (idx_bad) begin
									cmd_q.reply_en <= 1'b1;
									cmd_q.reply    <= RPL_ERROR;
								end else if (item.action == ACT_WRITE) begin
									cmd_q.host_wr  <= 1'b1;
									cmd_q.reply_en <= 1'b1;
									cmd_q.reply    <= RPL_ZERO;
									addr_q         <= idx_addr;
								end else begin
									cmd_q.rd_en <= 1'b1;
									addr_q      <= idx_addr;
									busy_q      <= 1'b1;
									state_q     <= ST_READ;
								end
							end
							default: begin
								cmd_q.reply_en <= 1'b1;
								cmd_q.reply    <= RPL_ZERO;
							end
						endcase
					end
				end
				ST_READ: begin
					cmd_q.reply_en <= 1'b1;
					cmd_q.reply    <= RPL_READ;
					busy_q         <= 1'b0;
					state_q        <= ST_IDLE;
				end
				ST_SWEEP: begin
					cmd_q.rd_en <= 1'b1;
					cmd_q.sweep <= 1'b1;
					addr_q      <= cnt_addr;
					cnt_q       <= cnt_q + 1'b1;
					if (cnt_q == last_cell) begin
						dcnt_q  <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DRAIN_LAST) begin
						if (cmd_q.pass == PASS_SLOPE) begin
							cmd_q.rd_en <= 1'b1;
							cmd_q.sweep <= 1'b1;
							cmd_q.wrap  <= 1'b1;
							cmd_q.pass  <= PASS_FINAL;
							addr_q      <= last_addr;
							cnt_q       <= '0;
							state_q     <= ST_SWEEP;
						end else begin
							cmd_q.reply_en <= 1'b1;
							cmd_q.reply    <= RPL_SAT;
							busy_q         <= 1'b0;
							state_q        <= ST_IDLE;
						end
					end
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/uas_datapath.sv
// ----------------------------------------------------------------------------
// uas_datapath
// grid and slope memories, three stage update pipeline, saturation and
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module uas_datapath #(
	parameter int GRID_CELLS = uas_pkg::GRID_CELLS_DEF,
	parameter int VALUE_BITS = uas_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_load,
	input  wire logic signed [uas_pkg::VALUE_W-1:0]   cell_value,
	input  uas_pkg::cfg_t                             cfg,
	input  uas_pkg::dp_cmd_t                          cmd,
	input  wire logic [$clog2(GRID_CELLS)-1:0]        addr,
	output logic                                      done,
	output uas_pkg::result_t                          result
);
	import uas_pkg::*;

	localparam int ADDR_W = $clog2(GRID_CELLS);
	localparam int VB     = VALUE_BITS;
	localparam int SW     = VB + 1;
	localparam int DW     = VB + 3;
	localparam int NVW    = DW + 1;
	localparam int PW     = DW + COURANT_W + 1;
	localparam int FRAC_W = COURANT_W - 1;
	localparam int IW     = (VB > VALUE_W) ? VB : VALUE_W;

	localparam logic signed [NVW-1:0] NV_MAX = {{(NVW-VB+1){1'b0}}, {(VB-1){1'b1}}};
	localparam logic signed [NVW-1:0] NV_MIN = {{(NVW-VB+1){1'b1}}, {(VB-1){1'b0}}};
	localparam logic signed [IW-1:0]  W_MAX  = {{(IW-VB+1){1'b0}}, {(VB-1){1'b1}}};
	localparam logic signed [IW-1:0]  W_MIN  = {{(IW-VB+1){1'b1}}, {(VB-1){1'b0}}};

	logic signed [VB-1:0]  grid_mem [GRID_CELLS];
	logic signed [SW-1:0]  slope_mem [GRID_CELLS];

	logic signed [VALUE_W-1:0] value_q;
	logic signed [VB-1:0]      left_g_q;
	logic signed [SW-1:0]      left_s_q;
	logic                      sat_q;
	logic                      done_q;
	result_t                   result_q;

	logic signed [VB-1:0]  rd_g_s1;
	logic signed [SW-1:0]  rd_s_s1;
	logic                  valid_s1;
	logic                  wrap_s1;
	logic [ADDR_W-1:0]     addr_s1;

	logic signed [DW-1:0]  diff_s2;
	logic signed [VB-1:0]  f_s2;
	logic signed [SW-1:0]  d_s2;
	logic                  valid_s2;
	logic [ADDR_W-1:0]     addr_s2;

	logic signed [DW-1:0]  e_s3;
	logic signed [VB-1:0]  f_s3;
	logic signed [SW-1:0]  d_s3;
	logic                  valid_s3;
	logic [ADDR_W-1:0]     addr_s3;

	logic signed [IW-1:0]  wx;
	logic signed [VB-1:0]  wval;
	logic signed [DW-1:0]  diff;
	logic signed [PW-1:0]  prod;
	logic signed [NVW-1:0] nv_half;
	logic signed [NVW-1:0] nv;
	logic signed [VB-1:0]  nv_clip;
	logic                  nv_sat;
	logic signed [IW-1:0]  rx;

	logic                  grid_we;
	logic [ADDR_W-1:0]     grid_wa;
	logic signed [VB-1:0]  grid_wd;
	logic                  slope_we;

	// host write value clipped into the cell range
	always_comb begin
		wx = IW'(value_q);
		if (wx > W_MAX) begin
			wval = W_MAX[VB-1:0];
		end else if (wx < W_MIN) begin
			wval = W_MIN[VB-1:0];
		end else begin
			wval = wx[VB-1:0];
		end
	end

	// stage 1: left minus current, or the rk2 second stage form
	always_comb begin
		if (cmd.pass == PASS_FINAL) begin
			diff = (DW'(left_g_q) + DW'(left_s_q)) - (DW'(rd_g_s1) + DW'(rd_s_s1));
		end else begin
			diff = DW'(left_g_q) - DW'(rd_g_s1);
		end
	end

	assign prod = $signed({1'b0, cfg.courant}) * diff_s2;

	// stage 3: new cell value and clip
	always_comb begin
		nv_half = (NVW'(d_s3) + NVW'(e_s3)) >>> 1;
		if (cmd.pass == PASS_FINAL) begin
			nv = NVW'(f_s3) + nv_half;
		end else begin
			nv = NVW'(f_s3) + NVW'(e_s3);
		end
		nv_sat = 1'b0;
		if (nv > NV_MAX) begin
			nv_clip = NV_MAX[VB-1:0];
			nv_sat  = 1'b1;
		end else if (nv < NV_MIN) begin
			nv_clip = NV_MIN[VB-1:0];
			nv_sat  = 1'b1;
		end else begin
			nv_clip = nv[VB-1:0];
		end
	end

	always_comb begin
		grid_we  = cmd.host_wr || (valid_s3 && (cmd.pass != PASS_SLOPE));
		grid_wa  = cmd.host_wr ? addr : addr_s3;
		grid_wd  = cmd.host_wr ? wval : nv_clip;
		slope_we = valid_s3 && (cmd.pass == PASS_SLOPE);
	end

	always_ff @(posedge clk) begin
		if (grid_we) begin
			grid_mem[grid_wa] <= grid_wd;
		end
		if (cmd.rd_en) begin
			rd_g_s1 <= grid_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (slope_we) begin
			slope_mem[addr_s3] <= e_s3[SW-1:0];
		end
		if (cmd.rd_en) begin
			rd_s_s1 <= slope_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) begin
			value_q <= cell_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			left_g_q <= '0;
			left_s_q <= '0;
			sat_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en && cmd.sweep;
			valid_s2 <= valid_s1 && !wrap_s1;
			valid_s3 <= valid_s2;
			// old values roll forward as the next cell's left neighbour
			if (valid_s1) begin
				left_g_q <= rd_g_s1;
				left_s_q <= rd_s_s1;
			end
			if (cmd.clr_sat) begin
				sat_q <= 1'b0;
			end else if (valid_s3 && (cmd.pass != PASS_SLOPE) && nv_sat) begin
				sat_q <= 1'b1;
			end
			done_q <= cmd.reply_en;
		end
	end

	always_ff @(posedge clk) begin
		wrap_s1 <= cmd.wrap;
		addr_s1 <= addr;
		if (valid_s1 && !wrap_s1) begin
			diff_s2 <= diff;
			f_s2    <= rd_g_s1;
			d_s2    <= rd_s_s1;
			addr_s2 <= addr_s1;
		end
		if (valid_s2) begin
			// floor of c * diff / 2^16
			e_s3    <= prod[FRAC_W +: DW];
			f_s3    <= f_s2;
			d_s3    <= d_s2;
			addr_s3 <= addr_s2;
		end
	end

	assign rx = IW'(rd_g_s1);

	always_ff @(posedge clk) begin
		if (cmd.reply_en) begin
			unique case (cmd.reply)
				RPL_ZERO: begin
					result_q <= '0;
				end
				RPL_ERROR: begin
					result_q             <= '0;
					result_q.index_error <= 1'b1;
				end
				RPL_READ: begin
					result_q            <= '0;
					result_q.read_value <= rx[VALUE_W-1:0];
				end
				RPL_SAT: begin
					result_q           <= '0;
					result_q.saturated <= sat_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: src/upwind_advection_stepper_top.sv
// ----------------------------------------------------------------------------
// upwind_advection_stepper_top
// periodic 1d grid of signed q8.16 cells with an euler or rk2 upwind timestep
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item gives one
// result, shown for one cycle with done high, and the receiver cannot stall
// it. Writes, bad indexes and the unused action keep busy low, so one can be
// taken each cycle; their reply command is registered, and done from it.
// A read holds busy for one cycle and answers once the read state has issued
// its reply. An advance walks the n cells in use through the single read port
// of the grid memory, one cell a cycle, then drains the three stage update
// pipeline, running a slope sweep before the update sweep in rk2 mode, with
// done in the cycle after busy falls. Cells are not cleared at reset; each
// cell in use must be written before it is read or advanced.
`default_nettype none

`include "upwind_advection_stepper_top_defines.svh"

module upwind_advection_stepper_top #(
	parameter int GRID_CELLS = uas_pkg::GRID_CELLS_DEF,
	parameter int VALUE_BITS = uas_pkg::VALUE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  uas_pkg::item_t                        item,
	output logic                                  done,
	output uas_pkg::result_t                      result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [uas_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [uas_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import uas_pkg::*;

	cfg_t                         cfg_view;
	dp_cmd_t                      cmd;
	logic [$clog2(GRID_CELLS)-1:0] cmd_addr;
	logic                         accept;
	logic                         bad_access;

	assign accept = start && !busy;
	assign bad_access = accept && (item.action == ACT_WRITE || item.action == ACT_READ)
		&& (CELLS_W'(item.cell_index) >= cfg_view.cells);

	uas_cfg #(
		.GRID_CELLS(GRID_CELLS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg_view)
	);

	uas_ctrl #(
		.GRID_CELLS(GRID_CELLS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.cfg    (cfg_view),
		.busy   (busy),
		.cmd    (cmd),
		.addr   (cmd_addr)
	);

	uas_datapath #(
		.GRID_CELLS(GRID_CELLS),
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_load  (accept),
		.cell_value (item.cell_value),
		.cfg        (cfg_view),
		.cmd        (cmd),
		.addr       (cmd_addr),
		.done       (done),
		.result     (result)
	);

	// an accepted advance holds the block busy
	`UAS_ASSERT_NXT(a_advance_busy, accept && item.action == ACT_ADVANCE, busy)

	// an out of range access is answered with a registered error reply command
	`UAS_ASSERT_NXT(a_index_error_reply, bad_access, cmd.reply_en && cmd.reply == RPL_ERROR)

	// no sweep reads leak out once the block is idle
	`UAS_ASSERT_IMP(a_idle_no_sweep, !busy, !cmd.sweep)

endmodule

`default_nettype wire
